// File: design/divider_64bit_signed_unsigned_top_assert.svh
// Assertion macros used by the divider controller.
// Depends on nothing; included by the modules that carry assertions.
`ifndef DIVIDER_64BIT_SIGNED_UNSIGNED_TOP_ASSERT_SVH
`define DIVIDER_64BIT_SIGNED_UNSIGNED_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define DIV_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define DIV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/div64_pkg.sv
// Shared constants and types of the 64-bit integer divider.
// Depends on nothing; used by the datapath, controller and top level.
package div64_pkg;

  // Width of the operand and result ports.
  localparam int PORT_W = 64;

  // Default number of significant operand bits.
  localparam int DATA_WIDTH_DEF = 64;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture operands and form magnitudes
    logic step;    // one restoring subtract-and-shift step
    logic finish;  // apply signs and write the result registers
  } dp_cmd_t;

endpackage

// File: design/div64_datapath.sv
// Datapath of the divider: operand magnitudes, radix-2 restoring divide, sign fix-up.
// Depends on div64_pkg for the port width and the command struct.
module div64_datapath #(
  parameter int DATA_WIDTH = div64_pkg::DATA_WIDTH_DEF
) (
  input  logic                      clk,
  input  div64_pkg::dp_cmd_t        cmd,
  input  logic                      op,
  input  logic [div64_pkg::PORT_W-1:0] dividend,
  input  logic [div64_pkg::PORT_W-1:0] divisor,
  output logic [div64_pkg::PORT_W-1:0] quotient,
  output logic [div64_pkg::PORT_W-1:0] remainder,
  output logic                      div_by_zero
);
  import div64_pkg::*;

  logic [DATA_WIDTH-1:0] a_in;
  logic [DATA_WIDTH-1:0] d_in;
  logic                  a_neg;
  logic                  d_neg;
  logic [DATA_WIDTH-1:0] a_mag;
  logic [DATA_WIDTH-1:0] d_mag;

  logic [DATA_WIDTH-1:0] quo_r, quo_nxt;
  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic [DATA_WIDTH-1:0] dvs_r, dvs_nxt;
  logic                  q_neg_r, q_neg_nxt;
  logic                  r_neg_r, r_neg_nxt;
  logic                  dz_r, dz_nxt;

  logic [DATA_WIDTH:0]   partial;
  logic [DATA_WIDTH:0]   trial;

  logic [DATA_WIDTH-1:0] q_fix;
  logic [DATA_WIDTH-1:0] r_fix;
  logic [PORT_W-1:0]     quotient_r, quotient_nxt;
  logic [PORT_W-1:0]     remainder_r, remainder_nxt;
  logic                  div_by_zero_r, div_by_zero_nxt;

  // Operand magnitudes; only the low DATA_WIDTH bits take part.
  assign a_in  = dividend[DATA_WIDTH-1:0];
  assign d_in  = divisor[DATA_WIDTH-1:0];
  assign a_neg = op & a_in[DATA_WIDTH-1];
  assign d_neg = op & d_in[DATA_WIDTH-1];
  assign a_mag = a_neg ? (~a_in + 1'b1) : a_in;
  assign d_mag = d_neg ? (~d_in + 1'b1) : d_in;

  // Trial subtraction of the divisor from the shifted partial remainder.
  assign partial = {rem_r, quo_r[DATA_WIDTH-1]};
  assign trial   = partial - {1'b0, dvs_r};

  // Signed fix-up of the finished quotient and remainder.
  assign q_fix = q_neg_r ? (~quo_r + 1'b1) : quo_r;
  assign r_fix = r_neg_r ? (~rem_r + 1'b1) : rem_r;

  // Next-state logic of the working and result registers.
  always_comb begin
    quo_nxt         = quo_r;
    rem_nxt         = rem_r;
    dvs_nxt         = dvs_r;
    q_neg_nxt       = q_neg_r;
    r_neg_nxt       = r_neg_r;
    dz_nxt          = dz_r;
    quotient_nxt    = quotient_r;
    remainder_nxt   = remainder_r;
    div_by_zero_nxt = div_by_zero_r;
    if (cmd.load) begin
      quo_nxt   = a_mag;
      rem_nxt   = '0;
      dvs_nxt   = d_mag;
      q_neg_nxt = a_neg ^ d_neg;
      r_neg_nxt = a_neg;
      dz_nxt    = (d_in == '0);
    end else if (cmd.step) begin
      if (trial[DATA_WIDTH]) begin
        rem_nxt = partial[DATA_WIDTH-1:0];
        quo_nxt = {quo_r[DATA_WIDTH-2:0], 1'b0};
      end else begin
        rem_nxt = trial[DATA_WIDTH-1:0];
        quo_nxt = {quo_r[DATA_WIDTH-2:0], 1'b1};
      end
    end
    if (cmd.finish) begin
      // A zero divisor forces both results to zero.
      quotient_nxt    = dz_r ? '0 : PORT_W'(q_fix);
      remainder_nxt   = dz_r ? '0 : PORT_W'(r_fix);
      div_by_zero_nxt = dz_r;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    quo_r         <= quo_nxt;
    rem_r         <= rem_nxt;
    dvs_r         <= dvs_nxt;
    q_neg_r       <= q_neg_nxt;
    r_neg_r       <= r_neg_nxt;
    dz_r          <= dz_nxt;
    quotient_r    <= quotient_nxt;
    remainder_r   <= remainder_nxt;
    div_by_zero_r <= div_by_zero_nxt;
  end

  assign quotient    = quotient_r;
  assign remainder   = remainder_r;
  assign div_by_zero = div_by_zero_r;

endmodule

// File: design/div64_ctrl.sv
// Controller of the divider: sequences load, the divide steps and the fix-up.
// Depends on div64_pkg for the command struct and on the assertion macro header.
`include "divider_64bit_signed_unsigned_top_assert.svh"

module div64_ctrl #(
  parameter int DATA_WIDTH = div64_pkg::DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output logic               out_valid,
  output div64_pkg::dp_cmd_t cmd
);
  import div64_pkg::*;

  localparam int CNT_W = $clog2(DATA_WIDTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FIXUP
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               accept;
  logic               last_step;

  assign accept    = start && (state_r == ST_IDLE);
  assign last_step = (count_r == CNT_W'(DATA_WIDTH - 1));

  // State transitions and the result strobe.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_DIVIDE;
          count_nxt = '0;
        end
      end
      ST_DIVIDE: begin
        count_nxt = count_r + 1'b1;
        if (last_step) begin
          state_nxt = ST_FIXUP;
        end
      end
      ST_FIXUP: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register and registered strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Commands to the datapath.
  assign cmd.load   = accept;
  assign cmd.step   = (state_r == ST_DIVIDE);
  assign cmd.finish = (state_r == ST_FIXUP);

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // An accepted request makes the block busy in the next cycle.
  `DIV_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy, "accepted request did not raise busy")
  // The result strobe follows the fix-up cycle only.
  `DIV_ASSERT_IMPL(a_valid_after_fixup, clk, rst_n, out_valid_r,
                   $past(state_r) == ST_FIXUP, "result strobe without fix-up")
  // The last divide step hands over to the fix-up cycle.
  `DIV_ASSERT_NEXT(a_last_to_fixup, clk, rst_n, (state_r == ST_DIVIDE) && last_step,
                   state_r == ST_FIXUP, "divide did not end in fix-up")

endmodule

// File: design/divider_64bit_signed_unsigned_top.sv
// Top level of the 64-bit signed/unsigned integer divider.
// Depends on div64_pkg, div64_ctrl and div64_datapath.
//
// Usage: a request is accepted at a rising edge where start is high and busy
// is low; in_op selects unsigned (0) or signed two's complement (1) division
// of in_dividend by in_divisor. Only the low DATA_WIDTH bits of each operand
// are used. The result appears on out_quotient, out_remainder and
// out_div_by_zero, marked by out_valid for exactly one cycle; the receiver
// cannot hold it off. The quotient is truncated toward zero and the remainder
// takes the dividend's sign. A zero divisor gives zero results with the flag.
// The quotient is produced one bit per cycle by a restoring subtract-and-shift
// step, and a fix-up state then applies the signs. A new request is taken
// only once the previous result is out; busy is low during the out_valid
// cycle, so the next request can enter then.
// Reset (rst_n low, synchronous) returns the controller to idle and drops any
// request in progress; no result is produced for it.
module divider_64bit_signed_unsigned_top #(
  parameter int DATA_WIDTH = div64_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_op,
  input  logic [div64_pkg::PORT_W-1:0] in_dividend,
  input  logic [div64_pkg::PORT_W-1:0] in_divisor,
  output logic                         out_valid,
  output logic [div64_pkg::PORT_W-1:0] out_quotient,
  output logic [div64_pkg::PORT_W-1:0] out_remainder,
  output logic                         out_div_by_zero
);
  import div64_pkg::*;

  dp_cmd_t cmd;

  // Sequencer.
  div64_ctrl #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Arithmetic.
  div64_datapath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .cmd         (cmd),
    .op          (in_op),
    .dividend    (in_dividend),
    .divisor     (in_divisor),
    .quotient    (out_quotient),
    .remainder   (out_remainder),
    .div_by_zero (out_div_by_zero)
  );

endmodule

// File: test/tb.sv
// Self-checking testbench for the 64-bit signed/unsigned integer divider.
// It compares every result against a behavioral quotient/remainder model.
// Depends on div64_pkg and divider_64bit_signed_unsigned_top.
module tb;

  localparam int W          = div64_pkg::PORT_W;
  localparam int DW         = div64_pkg::DATA_WIDTH_DEF;
  localparam int N_RANDOM   = 1530;
  localparam int CALM_FIRST = 400;
  localparam int CALM_LAST  = 800;
  localparam int STALL_MAX  = 2000;
  localparam int REPORT_MAX = 10;

  localparam logic OP_UNSIGNED = 1'b0;
  localparam logic OP_SIGNED   = 1'b1;

  localparam logic [W-1:0] OPND_MASK = {W{1'b1}} >> (W - DW);
  localparam logic [W-1:0] SIGN_MSB  = {{(W-1){1'b0}}, 1'b1} << (DW - 1);
  localparam logic [W-1:0] ALL_ONES  = OPND_MASK;
  localparam logic [W-1:0] MOST_NEG  = SIGN_MSB;
  localparam logic [W-1:0] MOST_POS  = OPND_MASK ^ SIGN_MSB;

  typedef struct packed {
    logic         op;
    logic [W-1:0] dividend;
    logic [W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic [W-1:0] quotient;
    logic [W-1:0] remainder;
    logic         div_by_zero;
  } div_res_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         start = 1'b0;
  logic         busy;
  logic         in_op = 1'b0;
  logic [W-1:0] in_dividend = '0;
  logic [W-1:0] in_divisor = '0;
  logic         out_valid;
  logic [W-1:0] out_quotient;
  logic [W-1:0] out_remainder;
  logic         out_div_by_zero;

  div_req_t div_requests[$];
  div_res_t quot_rem_expected[$];
  int       n_accepted = 0;
  int       n_errors = 0;
  int       stall_cycles = 0;

  divider_64bit_signed_unsigned_top uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_dividend    (in_dividend),
    .in_divisor     (in_divisor),
    .out_valid      (out_valid),
    .out_quotient   (out_quotient),
    .out_remainder  (out_remainder),
    .out_div_by_zero(out_div_by_zero)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Truncating division of the magnitudes, with the quotient sign taken from
  // the operand signs and the remainder sign from the dividend.
  function automatic div_res_t predict_division(logic op, logic [W-1:0] dividend,
                                                logic [W-1:0] divisor);
    div_res_t     res;
    logic [W-1:0] a;
    logic [W-1:0] d;
    logic         a_neg;
    logic         d_neg;
    a     = dividend & OPND_MASK;
    d     = divisor & OPND_MASK;
    a_neg = 1'b0;
    d_neg = 1'b0;
    res   = '0;
    if (d == '0) begin
      res.div_by_zero = 1'b1;
    end else if (a != '0) begin
      if (op == OP_SIGNED) begin
        a_neg = (a & SIGN_MSB) != '0;
        d_neg = (d & SIGN_MSB) != '0;
        if (a_neg) a = (-a) & OPND_MASK;
        if (d_neg) d = (-d) & OPND_MASK;
      end
      res.quotient  = (a / d) & OPND_MASK;
      res.remainder = (a % d) & OPND_MASK;
      if (a_neg != d_neg) res.quotient = (-res.quotient) & OPND_MASK;
      if (a_neg) res.remainder = (-res.remainder) & OPND_MASK;
    end
    return res;
  endfunction

  task automatic queue_division(logic op, logic [W-1:0] dividend, logic [W-1:0] divisor);
    div_requests.push_back('{op: op, dividend: dividend, divisor: divisor});
  endtask

  // Operands of varied length, so that every digit count of the dividend and
  // divisor shows up, with corner values mixed in.
  function automatic logic [W-1:0] rand_operand();
    logic [W-1:0] v;
    int           sel;
    v   = {$urandom, $urandom};
    sel = $urandom_range(0, 99);
    if (sel < 40) return v;
    if (sel < 78) return v >> $urandom_range(1, W - 1);
    if (sel < 88) return -(v >> $urandom_range(1, W - 1));
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return W'(1);
      2:       return ALL_ONES;
      3:       return MOST_NEG;
      4:       return MOST_POS;
      default: return MOST_NEG + W'(1);
    endcase
  endfunction

  // Driver: presents the next request at the falling edge, or idles with
  // random data on the inputs.
  int gap_left = 0;
  int seen_accepted = 0;
  always @(negedge clk) begin
    logic calm;
    calm = (n_accepted >= CALM_FIRST) && (n_accepted < CALM_LAST);
    if (n_accepted != seen_accepted) begin
      seen_accepted = n_accepted;
      if (!calm && $urandom_range(0, 99) < 19) gap_left = $urandom_range(1, 70);
    end
    if (!rst_n || n_accepted >= div_requests.size() || gap_left > 0 ||
        (!calm && $urandom_range(0, 99) < 19)) begin
      if (gap_left > 0) gap_left = gap_left - 1;
      start       <= 1'b0;
      in_op       <= 1'($urandom_range(0, 1));
      in_dividend <= {$urandom, $urandom};
      in_divisor  <= {$urandom, $urandom};
    end else begin
      start       <= 1'b1;
      in_op       <= div_requests[n_accepted].op;
      in_dividend <= div_requests[n_accepted].dividend;
      in_divisor  <= div_requests[n_accepted].divisor;
    end
  end

  // Monitor: checks each result against the oldest expectation and records
  // each accepted request.
  always @(posedge clk) begin
    div_res_t exp_res;
    if (rst_n) begin
      if (out_valid) begin
        if (quot_rem_expected.size() == 0) begin
          if (n_errors < REPORT_MAX)
            $display("Unexpected result: quotient %h remainder %h div_by_zero %b",
                     out_quotient, out_remainder, out_div_by_zero);
          n_errors++;
        end else begin
          exp_res = quot_rem_expected.pop_front();
          if (out_quotient !== exp_res.quotient || out_remainder !== exp_res.remainder ||
              out_div_by_zero !== exp_res.div_by_zero) begin
            if (n_errors < REPORT_MAX)
              $display("Mismatch: expected q %h r %h dz %b, got q %h r %h dz %b",
                       exp_res.quotient, exp_res.remainder, exp_res.div_by_zero,
                       out_quotient, out_remainder, out_div_by_zero);
            n_errors++;
          end
        end
      end
      if (start && !busy) begin
        quot_rem_expected.push_back(predict_division(in_op, in_dividend, in_divisor));
        n_accepted++;
      end
    end
  end

  // Watchdog: ends the run when no request is accepted for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_MAX) begin
      $display("FAIL");
      $finish;
    end
  end

  // Stimulus and end of test.
  initial begin
    logic op;
    // Directed requests: zero operands, division by zero, extremes, short
    // dividends and the wrapping most-negative by minus-one case.
    queue_division(OP_UNSIGNED, '0, '0);
    queue_division(OP_UNSIGNED, 64'd5, '0);
    queue_division(OP_UNSIGNED, '0, 64'd7);
    queue_division(OP_UNSIGNED, ALL_ONES, 64'd1);
    queue_division(OP_UNSIGNED, ALL_ONES, ALL_ONES);
    queue_division(OP_UNSIGNED, 64'd1, ALL_ONES);
    queue_division(OP_UNSIGNED, 64'h0000_0000_1234_5678, 64'h0000_0123_0000_0000);
    queue_division(OP_UNSIGNED, MOST_NEG, ALL_ONES);
    queue_division(OP_UNSIGNED, 64'hFEDC_BA98_7654_3210, 64'h0000_0000_0000_FFFF);
    queue_division(OP_UNSIGNED, 64'h8000_7FFF_0000_FFFF, 64'h0000_8000_0000_0001);
    queue_division(OP_SIGNED, MOST_NEG, ALL_ONES);
    queue_division(OP_SIGNED, MOST_NEG, 64'd1);
    queue_division(OP_SIGNED, -64'sd7, 64'd2);
    queue_division(OP_SIGNED, 64'd7, -64'sd2);
    queue_division(OP_SIGNED, -64'sd7, -64'sd2);
    queue_division(OP_SIGNED, ALL_ONES, MOST_NEG);
    queue_division(OP_SIGNED, MOST_NEG, MOST_NEG);
    queue_division(OP_SIGNED, 64'd5, '0);
    queue_division(OP_SIGNED, '0, '0);
    queue_division(OP_SIGNED, MOST_POS, ALL_ONES);
    queue_division(OP_SIGNED, '0, -64'sd5);
    queue_division(OP_SIGNED, 64'd3, -64'sd9);
    queue_division(OP_SIGNED, MOST_POS, MOST_NEG);
    queue_division(OP_SIGNED, MOST_NEG, MOST_POS);
    queue_division(OP_UNSIGNED, MOST_POS, MOST_NEG);
    for (int i = 0; i < N_RANDOM; i++) begin
      op = 1'($urandom_range(0, 1));
      queue_division(op, rand_operand(), rand_operand());
    end

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    wait (n_accepted == div_requests.size() && quot_rem_expected.size() == 0);
    repeat (DW + 8) @(posedge clk);
    if (n_errors == 0 && quot_rem_expected.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: divider_64bit_signed_unsigned_top.f
+incdir+design
design/div64_pkg.sv
design/div64_datapath.sv
design/div64_ctrl.sv
design/divider_64bit_signed_unsigned_top.sv
test/tb.sv
